@@ sv/rhct_pkg.sv @@
// ----------------------------------------------------------------------------
// rhct_pkg
// Types, constants and helpers shared by the color threshold pipeline.
// ----------------------------------------------------------------------------
package rhct_pkg;

  localparam int Levels = 8;
  localparam int Steps  = Levels - 1;
  localparam int Half   = 255 / (2 * Steps);
  localparam int StepQ  = 255 / Steps;
  localparam int StepR  = 255 % Steps;
  localparam int QuotBits    = 9;
  localparam int BitsPerStep = 3;
  localparam int DivStages   = QuotBits / BitsPerStep;
  localparam int NumBits     = 17;
  localparam int RemBits     = 10;

  localparam logic [2:0] RegHueLow  = 3'd0;
  localparam logic [2:0] RegHueHigh = 3'd1;
  localparam logic [2:0] RegSatLow  = 3'd2;
  localparam logic [2:0] RegSatHigh = 3'd3;
  localparam logic [2:0] RegValLow  = 3'd4;
  localparam logic [2:0] RegValHigh = 3'd5;
  localparam logic [2:0] RegQuant   = 3'd6;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [8:0] hue;
    logic [8:0] saturation;
    logic [7:0] brightness;
  } res_t;

  typedef struct packed {
    logic [8:0] hue_low;
    logic [8:0] hue_high;
    logic [8:0] sat_low;
    logic [8:0] sat_high;
    logic [7:0] val_low;
    logic [7:0] val_high;
    logic       quantize;
  } cfg_t;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } chan_t;

  typedef struct packed {
    logic [RemBits-1:0]  rem;
    logic [QuotBits-1:0] num;
    logic [QuotBits-1:0] quot;
    logic [8:0]          div;
  } divw_t;

  typedef struct packed {
    divw_t      sat;
    divw_t      hue;
    logic       hue_neg;
    logic [8:0] hue_base;
    logic [8:0] vmax;
  } divd_t;

  // level k is reached once c*Steps >= 255*k; its rebuilt value is
  // floor(255*k/Steps) + Half, accumulated step by step
  function automatic logic [8:0] rebuild(input logic [7:0] c);
    int base;
    int rem;
    logic [8:0] r;
    base = 0;
    rem  = 0;
    r    = 9'(Half);
    for (int k = 1; k <= Steps; k++) begin
      base = base + StepQ;
      rem  = rem + StepR;
      if (rem >= Steps) begin
        base = base + 1;
        rem  = rem - Steps;
      end
      if (int'(c) * Steps >= 255 * k) r = 9'(base + Half);
    end
    return r;
  endfunction

endpackage

@@ sv/rhct_front.sv @@
// ----------------------------------------------------------------------------
// rhct_front
// Optional channel quantization, then max/min and divider operand setup.
// ----------------------------------------------------------------------------
module rhct_front import rhct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  quantize_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  pix_t  data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output divd_t data_o
);

  logic  v1_q, v2_q, en1, en2;
  chan_t c_d, c_q;
  divd_t p_d, p_q;
  logic [8:0] vmax, vmin, delta, mag, vdiv;
  logic signed [9:0] diff;
  logic [16:0] hnum, snum;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign data_o  = p_q;

  always_comb begin
    if (quantize_i) begin
      c_d.red   = rebuild(data_i.red);
      c_d.green = rebuild(data_i.green);
      c_d.blue  = rebuild(data_i.blue);
    end else begin
      c_d.red   = {1'b0, data_i.red};
      c_d.green = {1'b0, data_i.green};
      c_d.blue  = {1'b0, data_i.blue};
    end
  end

  always_comb begin
    vmax = (c_q.red > c_q.green) ? c_q.red : c_q.green;
    if (c_q.blue > vmax) vmax = c_q.blue;
    vmin = (c_q.red < c_q.green) ? c_q.red : c_q.green;
    if (c_q.blue < vmin) vmin = c_q.blue;
    delta = vmax - vmin;
    if (c_q.red == vmax) begin
      diff = $signed({1'b0, c_q.green}) - $signed({1'b0, c_q.blue});
      p_d.hue_base = 9'd0;
    end else if (c_q.green == vmax) begin
      diff = $signed({1'b0, c_q.blue}) - $signed({1'b0, c_q.red});
      p_d.hue_base = 9'd120;
    end else begin
      diff = $signed({1'b0, c_q.red}) - $signed({1'b0, c_q.green});
      p_d.hue_base = 9'd240;
    end
    p_d.hue_neg = diff[9];
    mag  = diff[9] ? 9'(-diff) : diff[8:0];
    hnum = 17'(mag) * 17'd60;
    snum = {delta, 8'd0};
    vdiv = (vmax == 9'd0) ? 9'd1 : vmax;
    p_d.vmax = vmax;
    p_d.sat.rem  = {2'b00, snum[16:9]};
    p_d.sat.num  = snum[8:0];
    p_d.sat.quot = '0;
    p_d.sat.div  = vdiv;
    p_d.hue.rem  = {2'b00, hnum[16:9]};
    p_d.hue.num  = hnum[8:0];
    p_d.hue.quot = '0;
    p_d.hue.div  = (delta == 9'd0) ? 9'd1 : delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) c_q <= c_d;
    if (en2) p_q <= p_d;
  end

endmodule

@@ sv/rhct_div.sv @@
// ----------------------------------------------------------------------------
// rhct_div
// Pipelined restoring divider, a few quotient bits per stage, for the
// saturation and hue quotients side by side.
// ----------------------------------------------------------------------------
module rhct_div import rhct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  divd_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output divd_t data_o
);

  logic  [DivStages-1:0] v_q;
  logic  [DivStages-1:0] en;
  divd_t d_q [DivStages];
  divd_t d_d [DivStages];

  function automatic divw_t step(input divw_t w);
    divw_t o;
    logic [RemBits-1:0] t;
    o = w;
    for (int i = 0; i < BitsPerStep; i++) begin
      t = {o.rem[RemBits-2:0], o.num[QuotBits-1]};
      o.num = {o.num[QuotBits-2:0], 1'b0};
      if (t >= {1'b0, o.div}) begin
        o.rem  = t - {1'b0, o.div};
        o.quot = {o.quot[QuotBits-2:0], 1'b1};
      end else begin
        o.rem  = t;
        o.quot = {o.quot[QuotBits-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  assign ready_o = en[0];
  assign valid_o = v_q[DivStages-1];
  assign data_o  = d_q[DivStages-1];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    divd_t src;
    logic  vin;
    if (k == 0) begin : g_first
      assign src = data_i;
      assign vin = valid_i;
    end else begin : g_next
      assign src = d_q[k-1];
      assign vin = v_q[k-1];
    end
    if (k == DivStages - 1) begin : g_last
      assign en[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_comb begin
      d_d[k]     = src;
      d_d[k].sat = step(src.sat);
      d_d[k].hue = step(src.hue);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) d_q[k] <= d_d[k];
    end
  end

endmodule

@@ sv/rhct_back.sv @@
// ----------------------------------------------------------------------------
// rhct_back
// Hue sign and wrap, threshold tests and the output register.
// ----------------------------------------------------------------------------
module rhct_back import rhct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  divd_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o
);

  logic v_q, en;
  res_t r_d, r_q;
  logic signed [10:0] h;
  logic [8:0] hu, s;
  logic pass, hpass;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = r_q;

  always_comb begin
    if (data_i.hue_neg) begin
      h = $signed({2'b00, data_i.hue_base}) - $signed({2'b00, data_i.hue.quot});
    end else begin
      h = $signed({2'b00, data_i.hue_base}) + $signed({2'b00, data_i.hue.quot});
    end
    if (h < 0) h = h + 11'sd360;
    hu = h[8:0];
    s  = data_i.sat.quot;
    pass = (data_i.vmax >= {1'b0, cfg_i.val_low}) && (data_i.vmax <= {1'b0, cfg_i.val_high})
        && (s >= cfg_i.sat_low) && (s <= cfg_i.sat_high);
    if (cfg_i.hue_low < cfg_i.hue_high) begin
      hpass = (hu > cfg_i.hue_low) && (hu < cfg_i.hue_high);
    end else if (cfg_i.hue_low > cfg_i.hue_high) begin
      hpass = (hu > cfg_i.hue_low) || (hu < cfg_i.hue_high);
    end else begin
      hpass = 1'b0;
    end
    r_d.mask       = (pass && hpass) ? 8'd255 : 8'd0;
    r_d.hue        = hu;
    r_d.saturation = s;
    r_d.brightness = data_i.vmax[8] ? 8'd255 : data_i.vmax[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) r_q <= r_d;
  end

endmodule

@@ sv/rgb_hsv_color_threshold.sv @@
// ----------------------------------------------------------------------------
// rgb_hsv_color_threshold
// RGB pixel to integer HSV with a threshold mask.
// ----------------------------------------------------------------------------
// One pixel request enters on the input channel (valid/ready) and one result
// (mask, hue, saturation, brightness) leaves on the output channel.
// The pipeline stages are quantize, max/min setup, three divider stages of
// three quotient bits each, then the threshold and output register.
// Throughput is one pixel per cycle while the receiver is ready; the six-stage
// pipeline with valid bits in every stage sets that figure.
// Each stage holds when its successor is full and stalled, so empty stages
// still fill while the receiver holds off; nothing is lost or repeated.
// Thresholds (cfg_we_i/cfg_idx_i/cfg_data_i) must be written only while the
// pipeline is empty (the block does not enforce it); unknown indexes ignored.
// Reset clears all valid bits and loads the default thresholds:
// hue 320..40 exclusive, saturation 127..255, value 95..255, quantize on.
// ----------------------------------------------------------------------------
module rgb_hsv_color_threshold import rhct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pix_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_data_o
);

  cfg_t  cfg_q;
  logic  f_valid, f_ready, d_valid, d_ready;
  divd_t f_data, d_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= 9'd320;
      cfg_q.hue_high <= 9'd40;
      cfg_q.sat_low  <= 9'd127;
      cfg_q.sat_high <= 9'd255;
      cfg_q.val_low  <= 8'd95;
      cfg_q.val_high <= 8'd255;
      cfg_q.quantize <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHueLow:  cfg_q.hue_low  <= cfg_data_i;
        RegHueHigh: cfg_q.hue_high <= cfg_data_i;
        RegSatLow:  cfg_q.sat_low  <= cfg_data_i;
        RegSatHigh: cfg_q.sat_high <= cfg_data_i;
        RegValLow:  cfg_q.val_low  <= cfg_data_i[7:0];
        RegValHigh: cfg_q.val_high <= cfg_data_i[7:0];
        RegQuant:   cfg_q.quantize <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  rhct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .quantize_i (cfg_q.quantize),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .data_i     (in_data_i),
    .valid_o    (f_valid),
    .ready_i    (f_ready),
    .data_o     (f_data)
  );

  rhct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_data),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .data_o  (d_data)
  );

  rhct_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (d_valid),
    .ready_o (d_ready),
    .data_i  (d_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the color threshold pipeline: a scoreboard predicts mask and
// HSV per pixel request and checks each result in order, under random
// idling on both channels and several threshold settings.
// ----------------------------------------------------------------------------
class hsv_scoreboard;
  rhct_pkg::res_t pending[$];
  int errors;
  int checked;
  logic [8:0] hue_low, hue_high, sat_low, sat_high;
  logic [7:0] val_low, val_high;
  logic       quant;

  function new();
    errors = 0;
    checked = 0;
    hue_low = 320; hue_high = 40; sat_low = 127; sat_high = 255;
    val_low = 95; val_high = 255; quant = 1;
  endfunction

  function void set_reg(logic [2:0] idx, logic [8:0] data);
    case (idx)
      rhct_pkg::RegHueLow:  hue_low = data;
      rhct_pkg::RegHueHigh: hue_high = data;
      rhct_pkg::RegSatLow:  sat_low = data;
      rhct_pkg::RegSatHigh: sat_high = data;
      rhct_pkg::RegValLow:  val_low = data[7:0];
      rhct_pkg::RegValHigh: val_high = data[7:0];
      rhct_pkg::RegQuant:   quant = data[0];
      default: ;
    endcase
  endfunction

  function int requant(int c);
    int q;
    q = c * 7 / 255;
    return q * 255 / 7 + 255 / 14;
  endfunction

  function void note_pixel(rhct_pkg::pix_t p);
    int r, g, b, vmax, vmin, d, h, s;
    bit ok;
    rhct_pkg::res_t e;
    r = p.red; g = p.green; b = p.blue;
    if (quant) begin
      r = requant(r); g = requant(g); b = requant(b);
    end
    vmax = r > g ? r : g;
    if (b > vmax) vmax = b;
    vmin = r < g ? r : g;
    if (b < vmin) vmin = b;
    d = vmax - vmin;
    s = vmax != 0 ? 256 * d / vmax : 0;
    if (d == 0) d = 1;
    if (r == vmax) h = 60 * (g - b) / d;
    else if (g == vmax) h = 120 + 60 * (b - r) / d;
    else h = 240 + 60 * (r - g) / d;
    if (h < 0) h += 360;
    ok = vmax >= val_low && vmax <= val_high && s >= sat_low && s <= sat_high;
    if (ok) begin
      if (hue_low < hue_high) ok = h > hue_low && h < hue_high;
      else if (hue_low > hue_high) ok = h > hue_low || h < hue_high;
      else ok = 0;
    end
    e.mask = ok ? 8'd255 : 8'd0;
    e.hue = 9'(h);
    e.saturation = 9'(s);
    e.brightness = vmax > 255 ? 8'd255 : 8'(vmax);
    pending.push_back(e);
  endfunction

  function void check_result(rhct_pkg::res_t a);
    rhct_pkg::res_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, a);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (a.mask !== e.mask) begin
      $display("%0t: mask exp %0d got %0d", $time, e.mask, a.mask); errors++;
    end
    if (a.hue !== e.hue) begin
      $display("%0t: hue exp %0d got %0d", $time, e.hue, a.hue); errors++;
    end
    if (a.saturation !== e.saturation) begin
      $display("%0t: sat exp %0d got %0d", $time, e.saturation, a.saturation);
      errors++;
    end
    if (a.brightness !== e.brightness) begin
      $display("%0t: val exp %0d got %0d", $time, e.brightness, a.brightness);
      errors++;
    end
  endfunction
endclass

module tb;
  import rhct_pkg::*;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_we_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  pix_t       in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  res_t       out_data_o;

  hsv_scoreboard sb = new();
  int n_pix = 0;

  always #4 clk_i = ~clk_i;

  rgb_hsv_color_threshold i_dut (.*);

  task automatic write_reg(logic [2:0] idx, logic [8:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, data);
  endtask

  task automatic send_pixel(pix_t p);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1; in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
    n_pix++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_all(logic [8:0] hl, logic [8:0] hh, logic [8:0] sl, logic [8:0] sh,
                         logic [7:0] vl, logic [7:0] vh, logic q);
    write_reg(RegHueLow, hl); write_reg(RegHueHigh, hh);
    write_reg(RegSatLow, sl); write_reg(RegSatHigh, sh);
    write_reg(RegValLow, {1'b0, vl}); write_reg(RegValHigh, {1'b0, vh});
    write_reg(RegQuant, {8'd0, q});
  endtask

  task automatic random_pixels(int n);
    pix_t p;
    repeat (n) begin
      p = pix_t'($urandom);
      if ($urandom_range(0, 7) == 0) p.green = p.red;
      if ($urandom_range(0, 7) == 0) p.blue = p.red;
      send_pixel(p);
    end
  endtask

  // receiver side with random holdoff per result
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    // defaults, directed corners
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd40});
    send_pixel('{8'd200, 8'd30, 8'd10});
    send_pixel('{8'd128, 8'd128, 8'd0});
    drain();
    set_all(0, 359, 0, 256, 0, 255, 0);
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd1});
    send_pixel('{8'd1, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd1, 8'd255});
    send_pixel('{8'd10, 8'd200, 8'd100});
    drain();
    write_reg(RegHueLow, 100); write_reg(RegHueHigh, 100); // empty window
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd255, 8'd0, 8'd0});
    drain();
    write_reg(3'd7, 9'h1ff); // unknown index, ignored
    random_pixels(150);
    drain();
    set_all(320, 40, 127, 255, 95, 255, 1);
    random_pixels(150);
    drain();
    set_all(9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 8'hff, 8'hff, 1);
    random_pixels(60);
    drain();
    repeat (6) begin
      set_all(9'($urandom_range(0, 359)), 9'($urandom_range(0, 359)),
              9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
      random_pixels(70);
      drain();
    end
    $display("pixels sent %0d, results checked %0d over several threshold settings",
             n_pix, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
